>>> hw/rtl/mark_sweep_cell_heap_top_macros.svh
// Assertion macros used by the checker.
`ifndef MARK_SWEEP_CELL_HEAP_TOP_MACROS_SVH
`define MARK_SWEEP_CELL_HEAP_TOP_MACROS_SVH

// same-cycle implication
`define MSCH_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSCH_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/msch_pkg.sv
package msch_pkg;
  localparam int ADDR_W = 8;
  localparam int PTR_W  = 8;
  localparam int HEAP_SLOTS = 1 << ADDR_W;
  localparam int CHUNK_W = 16;
  localparam int CHUNKS  = HEAP_SLOTS / CHUNK_W;
  localparam int CHUNK_IDX_W = $clog2(CHUNKS);
  localparam int CHUNK_BIT_W = $clog2(CHUNK_W);

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_READ   = 2'd1,
    ACT_WRITE1 = 2'd2,
    ACT_WRITE2 = 2'd3
  } action_t;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_OOM = 1'b1;
endpackage

>>> hw/rtl/msch_ram.sv
module msch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/mark_sweep_cell_heap_top.sv
// Cell heap with mark-and-sweep collection. Cells 1..min(CELLS,255) each hold
// two 8-bit pointers (0 is nil) in two 256x8 RAMs. The free map and the mark map
// are 16x16 RAMs: one word per chunk of 16 cells. After reset, a clearing pass
// zeroes the cell RAMs and the mark map and loads the free map. in_ready stays
// low during that pass. The result of a write is registered and valid in the
// cycle after the transfer. A read passes through the RAM read register and the
// S_RD_WAIT state before its result is registered. An allocate starts at the
// lowest chunk that can hold a free cell and reads, then checks, one chunk after
// another. If no cell is free, the allocate collects. The root is marked by a
// mark read-modify-write. Each reachable cell then takes a queue read, a cell
// read, and a mark read-modify-write for each pointer. A final check finds the
// queue empty. A sweep frees the unmarked cells and clears the marks, and a
// rescan then starts from chunk 0. One item is in work at a time. A new item is
// taken once the result register is empty or being drained.
module mark_sweep_cell_heap_top
  import msch_pkg::*;
#(
  parameter int CELLS = 255
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        action,
  input  logic [ADDR_W-1:0] root,
  input  logic [ADDR_W-1:0] cell_address,
  input  logic [PTR_W-1:0]  pointer_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              status,
  output logic [ADDR_W-1:0] granted_address,
  output logic [PTR_W-1:0]  first_pointer,
  output logic [PTR_W-1:0]  second_pointer
);
  localparam int HEAP_TOP = (CELLS > HEAP_SLOTS - 1) ? HEAP_SLOTS - 1 : CELLS;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RD_WAIT, S_SEARCH_RD, S_SEARCH, S_MARK_RD, S_MARK_WR,
    S_WALK_RQ, S_WALK_Q, S_WALK_C, S_SWEEP_RD, S_SWEEP_WR
  } state_t;

  state_t state;

  logic [ADDR_W-1:0]      init_idx;
  logic [CHUNK_IDX_W-1:0] cursor;
  logic [CHUNK_IDX_W-1:0] sweep_idx;
  logic                   collected;
  logic [ADDR_W-1:0]      root_reg;
  logic [ADDR_W-1:0]      cand;
  logic [PTR_W-1:0]       second_reg;
  logic                   second_pending;
  logic [ADDR_W-1:0]      q_head;
  logic [ADDR_W-1:0]      q_tail;

  logic                   accept;
  logic                   in_heap_addr;
  logic                   w1_en, w2_en;
  logic                   init_chunk;
  logic                   grant_en;
  logic                   visit_en;
  logic [ADDR_W-1:0]      grant_addr;
  logic [ADDR_W-1:0]      cell_raddr, cell_waddr;
  logic                   first_we, second_we;
  logic [PTR_W-1:0]       first_wdata, second_wdata;
  logic [PTR_W-1:0]       first_rdata, second_rdata;
  logic [ADDR_W-1:0]      q_rdata;
  logic                   free_we;
  logic [CHUNK_IDX_W-1:0] free_waddr, free_raddr;
  logic [CHUNK_W-1:0]     free_wdata, free_rdata;
  logic                   mark_we;
  logic [CHUNK_IDX_W-1:0] mark_waddr, mark_raddr;
  logic [CHUNK_W-1:0]     mark_wdata, mark_rdata;
  logic [CHUNK_W-1:0]     cand_bit, grant_bit;
  logic [CHUNK_BIT_W-1:0] chunk_pick;
  logic                   chunk_any;

  function automatic logic in_heap(input logic [ADDR_W-1:0] a);
    in_heap = (a != '0) && (a <= ADDR_W'(HEAP_TOP));
  endfunction

  // cells of one chunk that lie inside the heap
  function automatic logic [CHUNK_W-1:0] heap_mask(input logic [CHUNK_IDX_W-1:0] idx);
    heap_mask = '0;
    for (int i = 0; i < CHUNK_W; i++) begin
      heap_mask[i] = in_heap({idx, CHUNK_BIT_W'(i)});
    end
  endfunction

  assign in_ready     = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept       = in_valid && in_ready;
  assign in_heap_addr = in_heap(cell_address);
  assign w1_en = accept && (action == ACT_WRITE1) && in_heap_addr;
  assign w2_en = accept && (action == ACT_WRITE2) && in_heap_addr;
  assign init_chunk = (state == S_INIT) && (init_idx < ADDR_W'(CHUNKS));
  assign grant_en   = (state == S_SEARCH) && chunk_any;
  assign grant_addr = {cursor, chunk_pick};
  assign grant_bit  = CHUNK_W'(1) << chunk_pick;
  assign cand_bit   = CHUNK_W'(1) << cand[CHUNK_BIT_W-1:0];
  assign visit_en   = (state == S_MARK_WR) && in_heap(cand) && !(|(mark_rdata & cand_bit));

  // cell RAMs: clearing pass, clearing of a granted cell, pointer writes
  assign cell_raddr   = (state == S_WALK_Q) ? q_rdata : cell_address;
  assign cell_waddr   = (state == S_INIT) ? init_idx : (grant_en ? grant_addr : cell_address);
  assign first_we     = (state == S_INIT) || grant_en || w1_en;
  assign second_we    = (state == S_INIT) || grant_en || w2_en;
  assign first_wdata  = w1_en ? pointer_value : '0;
  assign second_wdata = w2_en ? pointer_value : '0;

  msch_ram #(.WIDTH(PTR_W), .DEPTH(HEAP_SLOTS)) u_first_ram (
    .clk(clk), .we(first_we), .waddr(cell_waddr), .wdata(first_wdata),
    .raddr(cell_raddr), .rdata(first_rdata)
  );

  msch_ram #(.WIDTH(PTR_W), .DEPTH(HEAP_SLOTS)) u_second_ram (
    .clk(clk), .we(second_we), .waddr(cell_waddr), .wdata(second_wdata),
    .raddr(cell_raddr), .rdata(second_rdata)
  );

  msch_ram #(.WIDTH(ADDR_W), .DEPTH(HEAP_SLOTS)) u_queue_ram (
    .clk(clk), .we(visit_en), .waddr(q_tail), .wdata(cand),
    .raddr(q_head), .rdata(q_rdata)
  );

  assign free_raddr = (state == S_SWEEP_RD) ? sweep_idx : cursor;
  assign free_waddr = (state == S_INIT) ? init_idx[CHUNK_IDX_W-1:0] :
                      ((state == S_SWEEP_WR) ? sweep_idx : cursor);
  assign free_we    = init_chunk || grant_en || (state == S_SWEEP_WR);

  always_comb begin
    priority if (state == S_INIT) begin
      free_wdata = heap_mask(init_idx[CHUNK_IDX_W-1:0]);
    end else if (state == S_SWEEP_WR) begin
      free_wdata = free_rdata | (~mark_rdata & heap_mask(sweep_idx));
    end else begin
      free_wdata = free_rdata & ~grant_bit;
    end
  end

  msch_ram #(.WIDTH(CHUNK_W), .DEPTH(CHUNKS)) u_free_ram (
    .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
    .raddr(free_raddr), .rdata(free_rdata)
  );

  // marks are cleared by the sweep, so every collection starts unmarked
  assign mark_raddr = (state == S_SWEEP_RD) ? sweep_idx : cand[ADDR_W-1:CHUNK_BIT_W];
  assign mark_waddr = (state == S_INIT) ? init_idx[CHUNK_IDX_W-1:0] :
                      ((state == S_SWEEP_WR) ? sweep_idx : cand[ADDR_W-1:CHUNK_BIT_W]);
  assign mark_we    = init_chunk || (state == S_SWEEP_WR) || visit_en;
  assign mark_wdata = visit_en ? (mark_rdata | cand_bit) : '0;

  msch_ram #(.WIDTH(CHUNK_W), .DEPTH(CHUNKS)) u_mark_ram (
    .clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
    .raddr(mark_raddr), .rdata(mark_rdata)
  );

  always_comb begin
    chunk_any  = |free_rdata;
    chunk_pick = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      if (free_rdata[i]) begin
        chunk_pick = CHUNK_BIT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_INIT;
      out_valid      <= 1'b0;
      init_idx       <= '0;
      cursor         <= '0;
      sweep_idx      <= '0;
      collected      <= 1'b0;
      second_pending <= 1'b0;
      q_head         <= '0;
      q_tail         <= '0;
    end else begin
      if (out_valid && out_ready && !accept) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          init_idx <= init_idx + 1'b1;
          if (init_idx == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            root_reg  <= root;
            collected <= 1'b0;
            status          <= STATUS_OK;
            granted_address <= '0;
            first_pointer   <= '0;
            second_pointer  <= '0;
            priority case (action)
              ACT_ALLOC: begin
                out_valid <= 1'b0;
                state     <= S_SEARCH_RD;
              end
              ACT_READ: begin
                if (in_heap_addr) begin
                  out_valid <= 1'b0;
                  state     <= S_RD_WAIT;
                end else begin
                  out_valid <= 1'b1;
                end
              end
              default: out_valid <= 1'b1;
            endcase
          end
        end
        S_RD_WAIT: begin
          first_pointer  <= first_rdata;
          second_pointer <= second_rdata;
          out_valid      <= 1'b1;
          state          <= S_IDLE;
        end
        S_SEARCH_RD: state <= S_SEARCH;
        S_SEARCH: begin
          if (chunk_any) begin
            granted_address <= grant_addr;
            out_valid       <= 1'b1;
            state           <= S_IDLE;
          end else if (cursor != CHUNK_IDX_W'(CHUNKS - 1)) begin
            cursor <= cursor + 1'b1;
            state  <= S_SEARCH_RD;
          end else if (collected) begin
            status    <= STATUS_OOM;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            q_head         <= '0;
            q_tail         <= '0;
            cand           <= root_reg;
            second_pending <= 1'b0;
            state          <= S_MARK_RD;
          end
        end
        S_MARK_RD: state <= S_MARK_WR;
        S_MARK_WR: begin
          if (visit_en) q_tail <= q_tail + 1'b1;
          if (second_pending) begin
            cand           <= second_reg;
            second_pending <= 1'b0;
            state          <= S_MARK_RD;
          end else begin
            state <= S_WALK_RQ;
          end
        end
        S_WALK_RQ: begin
          if (q_head == q_tail) begin
            sweep_idx <= '0;
            state     <= S_SWEEP_RD;
          end else begin
            q_head <= q_head + 1'b1;
            state  <= S_WALK_Q;
          end
        end
        S_WALK_Q: state <= S_WALK_C;
        S_WALK_C: begin
          cand           <= first_rdata;
          second_reg     <= second_rdata;
          second_pending <= 1'b1;
          state          <= S_MARK_RD;
        end
        S_SWEEP_RD: state <= S_SWEEP_WR;
        S_SWEEP_WR: begin
          if (sweep_idx == CHUNK_IDX_W'(CHUNKS - 1)) begin
            cursor    <= '0;
            collected <= 1'b1;
            state     <= S_SEARCH_RD;
          end else begin
            sweep_idx <= sweep_idx + 1'b1;
            state     <= S_SWEEP_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hw/rtl/msch_checker.sv
`include "mark_sweep_cell_heap_top_macros.svh"

module msch_checker
  import msch_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic              status,
  input logic [ADDR_W-1:0] granted_address,
  input logic [PTR_W-1:0]  first_pointer,
  input logic [PTR_W-1:0]  second_pointer
);
  `MSCH_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(granted_address), "result dropped while stalled")
  `MSCH_ASSERT_IMP(a_oom_no_grant, out_valid && (status == STATUS_OOM), granted_address == '0, "grant with out-of-memory")
  `MSCH_ASSERT_IMP(a_grant_clean, out_valid && (granted_address != '0), (status == STATUS_OK) && (first_pointer == '0) && (second_pointer == '0), "grant with other fields set")
endmodule

bind mark_sweep_cell_heap_top msch_checker u_msch_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .status(status), .granted_address(granted_address),
  .first_pointer(first_pointer), .second_pointer(second_pointer)
);
